// ----- sv/mcpi_pkg.sv -----
// Shared types, constants and width helpers for the motor current PI loop.
// Used by mcpi_ctrl, mcpi_dp and motor_current_pi_loop; depends on nothing.
package mcpi_pkg;

    // Default values of the top-level parameters
    localparam int COUNTS_PER_REV_DEF = 1200;
    localparam int NUM_CHANNELS_DEF   = 2;

    // Fixed-point constants (Q16.16)
    localparam int Q16_ONE      = 65536;
    localparam int RND_HALF     = 32768;
    localparam int TWO_PI_Q16   = 411775;
    localparam int ZERO_AMP_Q16 = 983040;

    // Channel codes that a one-bit channel field can carry
    localparam int CHANNEL_CODES = 2;

    // Field and datapath widths
    localparam int CFG_DATA_W  = 27;
    localparam int CFG_IDX_W   = 3;
    localparam int GAIN_W      = 24;
    localparam int LIMIT_W     = 27;
    localparam int RECIP_W     = 17;
    localparam int DUTY_W      = 17;
    localparam int CODE_W      = 16;
    localparam int VEL_W       = 24;
    localparam int AMP_W       = 21;
    localparam int ERR_W       = 22;
    localparam int INTEG_W     = 28;
    localparam int VOLT_W      = 33;
    localparam int MUL_A_W     = 25;
    localparam int DUTY_PROD_W = VOLT_W + RECIP_W;

    // Volts saturate at 2^32: any larger magnitude already pins the duty clamp
    localparam logic [VOLT_W-1:0] VOLT_SAT = 33'h1_0000_0000;

    // Quotient bits retired per divider cycle
    localparam int DIV_STEP_BITS = 6;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDING_RES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_K    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_RCP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT  = 3'd6;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  winding_resistance;
        logic [GAIN_W-1:0]  torque_constant;
        logic [LIMIT_W-1:0] integ_limit;
        logic [RECIP_W-1:0] supply_recip;
        logic [DUTY_W-1:0]  duty_limit;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VEL,
        S_LOAD,
        S_DIV,
        S_KT,
        S_SUM,
        S_MAG,
        S_VOLT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VEL,
        MUL_RES,
        MUL_PROP,
        MUL_INTEG,
        MUL_TORQUE,
        MUL_DUTY
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_VEL
    } t_acc_op;

    typedef struct packed {
        logic     in_ready;
        logic     take;
        logic     integ_upd;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     div_load;
        logic     div_step;
        logic     mag_en;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_sts;

    // Largest dividend of the rad/s conversion, rounding offset included
    function automatic longint div_num_max(input int cpr);
        return (longint'(1) << (VEL_W - 1)) * longint'(TWO_PI_Q16) + longint'(cpr >> 1);
    endfunction

    function automatic int div_num_w(input int cpr);
        return $clog2(div_num_max(cpr) + 1);
    endfunction

    function automatic int div_iter(input int cpr);
        return (div_num_w(cpr) + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    endfunction

endpackage

// ----- sv/mcpi_ctrl.sv -----
// Sequencer for the motor current PI loop: steps one tick through the datapath.
// Depends on mcpi_pkg for the state, command and status types.
module mcpi_ctrl #(
    parameter int DIV_ITER = mcpi_pkg::div_iter(mcpi_pkg::COUNTS_PER_REV_DEF)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mcpi_pkg::t_sts  i_sts,
    output mcpi_pkg::t_cmd  o_cmd
);

    localparam int CNT_W = $clog2(DIV_ITER);

    mcpi_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             div_last;

    assign div_last = (r_cnt == CNT_W'(DIV_ITER - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcpi_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            mcpi_pkg::S_IDLE: begin
                if (i_sts.in_valid) n_state = mcpi_pkg::S_VEL;
            end
            mcpi_pkg::S_VEL:  n_state = mcpi_pkg::S_LOAD;
            mcpi_pkg::S_LOAD: n_state = mcpi_pkg::S_DIV;
            mcpi_pkg::S_DIV: begin
                if (div_last) begin
                    n_state = mcpi_pkg::S_KT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            mcpi_pkg::S_KT:   n_state = mcpi_pkg::S_SUM;
            mcpi_pkg::S_SUM:  n_state = mcpi_pkg::S_MAG;
            mcpi_pkg::S_MAG:  n_state = mcpi_pkg::S_VOLT;
            mcpi_pkg::S_VOLT: n_state = mcpi_pkg::S_DONE;
            mcpi_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = mcpi_pkg::S_IDLE;
            end
            default: n_state = mcpi_pkg::S_IDLE;
        endcase
    end

    // Commands; products overlap the divider iterations
    always_comb begin
        o_cmd = '{
            in_ready:  1'b0,
            take:      1'b0,
            integ_upd: 1'b0,
            mul_sel:   mcpi_pkg::MUL_NONE,
            acc_op:    mcpi_pkg::ACC_HOLD,
            div_load:  1'b0,
            div_step:  1'b0,
            mag_en:    1'b0,
            out_load:  1'b0
        };
        unique case (r_state)
            mcpi_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.take     = i_sts.in_valid;
            end
            mcpi_pkg::S_VEL: begin
                o_cmd.integ_upd = 1'b1;
                o_cmd.mul_sel   = mcpi_pkg::MUL_VEL;
            end
            mcpi_pkg::S_LOAD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.mul_sel  = mcpi_pkg::MUL_RES;
            end
            mcpi_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(0)) begin
                    o_cmd.acc_op  = mcpi_pkg::ACC_LOAD;
                    o_cmd.mul_sel = mcpi_pkg::MUL_PROP;
                end else if (r_cnt == CNT_W'(1)) begin
                    o_cmd.acc_op  = mcpi_pkg::ACC_ADD;
                    o_cmd.mul_sel = mcpi_pkg::MUL_INTEG;
                end else if (r_cnt == CNT_W'(2)) begin
                    o_cmd.acc_op  = mcpi_pkg::ACC_ADD;
                end
            end
            mcpi_pkg::S_KT:   o_cmd.mul_sel  = mcpi_pkg::MUL_TORQUE;
            mcpi_pkg::S_SUM:  o_cmd.acc_op   = mcpi_pkg::ACC_ADD_VEL;
            mcpi_pkg::S_MAG:  o_cmd.mag_en   = 1'b1;
            mcpi_pkg::S_VOLT: o_cmd.mul_sel  = mcpi_pkg::MUL_DUTY;
            mcpi_pkg::S_DONE: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ----- sv/mcpi_dp.sv -----
// Datapath of the motor current PI loop: input latch, integrators, shared
// multiplier, accumulator and radix-64 constant divider. Depends on mcpi_pkg.
module mcpi_dp #(
    parameter int COUNTS_PER_REV = mcpi_pkg::COUNTS_PER_REV_DEF,
    parameter int NUM_CHANNELS   = mcpi_pkg::NUM_CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mcpi_pkg::t_cmd                    i_cmd,
    input  mcpi_pkg::t_cfg                    i_cfg,
    input  logic                              i_channel,
    input  logic [mcpi_pkg::CODE_W-1:0]       i_current_raw,
    input  logic signed [mcpi_pkg::VEL_W-1:0] i_velocity_counts,
    input  logic signed [mcpi_pkg::AMP_W-1:0] i_desired_current,
    output logic                              o_channel,
    output logic [mcpi_pkg::DUTY_W-1:0]       o_duty,
    output logic                              o_reverse,
    output logic signed [mcpi_pkg::AMP_W-1:0] o_meas
);

    localparam int     NUM_W    = mcpi_pkg::div_num_w(COUNTS_PER_REV);
    localparam int     DIV_ITER = mcpi_pkg::div_iter(COUNTS_PER_REV);
    localparam int     NP       = DIV_ITER * mcpi_pkg::DIV_STEP_BITS;
    localparam int     SB       = mcpi_pkg::DIV_STEP_BITS;
    localparam longint QMAX     = mcpi_pkg::div_num_max(COUNTS_PER_REV) / COUNTS_PER_REV;
    localparam int     QW       = $clog2(QMAX + 1);
    localparam int     DW       = $clog2(COUNTS_PER_REV + 1);
    localparam int     HALF     = COUNTS_PER_REV >> 1;
    localparam int     BW       = ((QW > mcpi_pkg::VOLT_W) ? QW : mcpi_pkg::VOLT_W) + 1;
    localparam int     AW_M     = mcpi_pkg::MUL_A_W;
    localparam int     PW       = AW_M + BW;
    localparam int     AW       = PW + 2;
    localparam int     VW       = AW - 16;
    localparam int     IDEPTH   = (NUM_CHANNELS < mcpi_pkg::CHANNEL_CODES) ?
                                  NUM_CHANNELS : mcpi_pkg::CHANNEL_CODES;
    localparam int     IW       = mcpi_pkg::INTEG_W;
    localparam int     EW       = mcpi_pkg::ERR_W;

    // Latched tick
    logic                     r_ch;
    logic signed [20:0]       r_meas;
    logic signed [20:0]       r_ides;
    logic                     r_vneg;
    logic [23:0]              r_cmag;

    // Integrators
    logic signed [IW-1:0]     r_integ_mem [IDEPTH];
    logic signed [IW-1:0]     r_integ;

    // Arithmetic
    logic signed [PW-1:0]     r_prod;
    logic signed [AW-1:0]     r_acc;
    logic [NP-1:0]            r_num;
    logic [DW-1:0]            r_rem;
    logic [QW-1:0]            r_quot;
    logic [mcpi_pkg::VOLT_W-1:0] r_volts;
    logic                     r_neg;

    logic [20:0]              amps_code;
    logic signed [21:0]       meas_wide;
    logic signed [EW-1:0]     err;
    logic signed [IW-1:0]     integ_rd;
    logic signed [IW:0]       integ_sum;
    logic signed [IW:0]       lim_pos;
    logic signed [IW:0]       lim_neg;
    logic signed [IW-1:0]     integ_new;
    logic signed [AW_M-1:0]   mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [AW-1:0]     prod_ext;
    logic [DW-1:0]            div_rem;
    logic [SB-1:0]            div_q;
    logic signed [AW-1:0]     rnd;
    logic [VW-1:0]            vfull;
    logic [mcpi_pkg::DUTY_PROD_W:0] dsum;
    logic [mcpi_pkg::DUTY_PROD_W-16:0] dfull;
    logic [mcpi_pkg::DUTY_W-1:0] dlim;

    // 30 * code as 32*code - 2*code
    assign amps_code = {i_current_raw, 5'b0} - {4'b0, i_current_raw, 1'b0};
    assign meas_wide = 22'(mcpi_pkg::ZERO_AMP_Q16) - $signed({1'b0, amps_code});

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ch   <= i_channel;
            r_meas <= meas_wide[20:0];
            r_ides <= i_desired_current;
            r_vneg <= i_velocity_counts[23];
            r_cmag <= i_velocity_counts[23] ? (~i_velocity_counts + 24'd1)
                                            : i_velocity_counts;
        end
    end

    assign err = {r_ides[20], r_ides} - {r_meas[20], r_meas};

    // Channel select; a channel without an integrator reads zero
    always_comb begin
        integ_rd = '0;
        for (int e = 0; e < IDEPTH; e++) begin
            if (r_ch == 1'(e)) integ_rd = r_integ_mem[e];
        end
    end

    assign integ_sum = {integ_rd[IW-1], integ_rd} + {{(IW+1-EW){err[EW-1]}}, err};
    assign lim_pos   = {2'b0, i_cfg.integ_limit};
    assign lim_neg   = -lim_pos;

    always_comb begin
        if (integ_sum > lim_pos) begin
            integ_new = lim_pos[IW-1:0];
        end else if (integ_sum < lim_neg) begin
            integ_new = lim_neg[IW-1:0];
        end else begin
            integ_new = integ_sum[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < IDEPTH; e++) r_integ_mem[e] <= '0;
        end else if (i_cmd.integ_upd) begin
            for (int e = 0; e < IDEPTH; e++) begin
                if (r_ch == 1'(e)) r_integ_mem[e] <= integ_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.integ_upd) r_integ <= integ_new;
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_sel)
            mcpi_pkg::MUL_NONE: ;
            mcpi_pkg::MUL_VEL: begin
                mul_a = {1'b0, r_cmag};
                mul_b = BW'(mcpi_pkg::TWO_PI_Q16);
            end
            mcpi_pkg::MUL_RES: begin
                mul_a = {1'b0, i_cfg.winding_resistance};
                mul_b = {{(BW-21){r_ides[20]}}, r_ides};
            end
            mcpi_pkg::MUL_PROP: begin
                mul_a = {1'b0, i_cfg.prop_gain};
                mul_b = {{(BW-EW){err[EW-1]}}, err};
            end
            mcpi_pkg::MUL_INTEG: begin
                mul_a = {1'b0, i_cfg.integ_gain};
                mul_b = {{(BW-IW){r_integ[IW-1]}}, r_integ};
            end
            mcpi_pkg::MUL_TORQUE: begin
                mul_a = {1'b0, i_cfg.torque_constant};
                mul_b = {{(BW-QW){1'b0}}, r_quot};
            end
            mcpi_pkg::MUL_DUTY: begin
                mul_a = {{(AW_M-mcpi_pkg::RECIP_W){1'b0}}, i_cfg.supply_recip};
                mul_b = {{(BW-mcpi_pkg::VOLT_W){1'b0}}, r_volts};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != mcpi_pkg::MUL_NONE) r_prod <= mul_a * mul_b;
    end

    // Accumulate the four voltage terms; torque term follows velocity sign
    assign prod_ext = {{(AW-PW){r_prod[PW-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            mcpi_pkg::ACC_LOAD:    r_acc <= prod_ext;
            mcpi_pkg::ACC_ADD:     r_acc <= r_acc + prod_ext;
            mcpi_pkg::ACC_ADD_VEL: r_acc <= r_vneg ? (r_acc - prod_ext) : (r_acc + prod_ext);
            default: ;
        endcase
    end

    // Restoring division by COUNTS_PER_REV, SB quotient bits a cycle
    always_comb begin
        logic [DW:0] trial;
        div_rem = r_rem;
        div_q   = '0;
        for (int k = 0; k < SB; k++) begin
            trial = {div_rem, r_num[NP-1-k]};
            if (trial >= (DW+1)'(COUNTS_PER_REV)) begin
                div_rem       = DW'(trial - (DW+1)'(COUNTS_PER_REV));
                div_q[SB-1-k] = 1'b1;
            end else begin
                div_rem = trial[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num  <= NP'(r_prod[NUM_W-1:0]) + NP'(HALF);
            r_rem  <= '0;
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= r_num << SB;
            r_rem  <= div_rem;
            r_quot <= QW'({r_quot, div_q});
        end
    end

    // Round the voltage magnitude to Q16.16 and saturate it
    assign rnd   = r_acc[AW-1] ? (AW'(mcpi_pkg::RND_HALF) - r_acc)
                               : (r_acc + AW'(mcpi_pkg::RND_HALF));
    assign vfull = rnd[AW-1:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mag_en) begin
            r_neg   <= r_acc[AW-1];
            r_volts <= (vfull > {{(VW-mcpi_pkg::VOLT_W){1'b0}}, mcpi_pkg::VOLT_SAT})
                       ? mcpi_pkg::VOLT_SAT : vfull[mcpi_pkg::VOLT_W-1:0];
        end
    end

    // Duty rounding and clamp
    assign dsum  = {1'b0, r_prod[mcpi_pkg::DUTY_PROD_W-1:0]}
                 + (mcpi_pkg::DUTY_PROD_W+1)'(mcpi_pkg::RND_HALF);
    assign dfull = dsum[mcpi_pkg::DUTY_PROD_W:16];
    assign dlim  = (i_cfg.duty_limit > mcpi_pkg::DUTY_W'(mcpi_pkg::Q16_ONE))
                 ? mcpi_pkg::DUTY_W'(mcpi_pkg::Q16_ONE) : i_cfg.duty_limit;

    assign o_duty    = (dfull > {{(mcpi_pkg::DUTY_PROD_W-15-mcpi_pkg::DUTY_W){1'b0}}, dlim})
                     ? dlim : dfull[mcpi_pkg::DUTY_W-1:0];
    assign o_reverse = r_neg && (o_duty != '0);
    assign o_channel = r_ch;
    assign o_meas    = r_meas;

endmodule

// ----- sv/motor_current_pi_loop.sv -----
// Two-channel PI motor current controller with feedforward and anti-windup.
// The length of one tick is set by the radix-64 divider for rad/s and the one shared multiplier.
// A result is registered as S_DONE ends with the output free; only then is a new input taken.
// Synchronous active-low reset clears the sequencer, output valid, both integrators
// and the register file (gains zero, duty limit full scale).
module motor_current_pi_loop #(
    parameter int COUNTS_PER_REV = mcpi_pkg::COUNTS_PER_REV_DEF,
    parameter int NUM_CHANNELS   = mcpi_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // tick input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_channel,
    input  logic [mcpi_pkg::CODE_W-1:0]            i_current_raw,
    input  logic signed [mcpi_pkg::VEL_W-1:0]      i_velocity_counts,
    input  logic signed [mcpi_pkg::AMP_W-1:0]      i_desired_current,
    // drive command output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_out_channel,
    output logic [mcpi_pkg::DUTY_W-1:0]            o_duty_magnitude,
    output logic                                   o_reverse,
    output logic signed [mcpi_pkg::AMP_W-1:0]      o_measured_current,
    // register writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mcpi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mcpi_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int DIV_ITER = mcpi_pkg::div_iter(COUNTS_PER_REV);

    mcpi_pkg::t_cfg r_cfg;
    mcpi_pkg::t_cmd cmd;
    mcpi_pkg::t_sts sts;

    logic                               dp_channel;
    logic [mcpi_pkg::DUTY_W-1:0]        dp_duty;
    logic                               dp_reverse;
    logic signed [mcpi_pkg::AMP_W-1:0]  dp_meas;

    logic                               r_out_valid;
    logic                               r_out_channel;
    logic [mcpi_pkg::DUTY_W-1:0]        r_duty;
    logic                               r_reverse;
    logic signed [mcpi_pkg::AMP_W-1:0]  r_meas;

    // Register file: writes always complete; an unknown index is dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                prop_gain:          '0,
                integ_gain:         '0,
                winding_resistance: '0,
                torque_constant:    '0,
                integ_limit:        '0,
                supply_recip:       '0,
                duty_limit:         mcpi_pkg::DUTY_W'(mcpi_pkg::Q16_ONE)
            };
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mcpi_pkg::REG_PROP_GAIN:   r_cfg.prop_gain          <= i_cfg_data[23:0];
                mcpi_pkg::REG_INTEG_GAIN:  r_cfg.integ_gain         <= i_cfg_data[23:0];
                mcpi_pkg::REG_WINDING_RES: r_cfg.winding_resistance <= i_cfg_data[23:0];
                mcpi_pkg::REG_TORQUE_K:    r_cfg.torque_constant    <= i_cfg_data[23:0];
                mcpi_pkg::REG_INTEG_LIMIT: r_cfg.integ_limit        <= i_cfg_data[26:0];
                mcpi_pkg::REG_SUPPLY_RCP:  r_cfg.supply_recip       <= i_cfg_data[16:0];
                mcpi_pkg::REG_DUTY_LIMIT:  r_cfg.duty_limit         <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Input takes a transaction only while the sequencer is idle
    assign o_in_stall   = !cmd.in_ready;
    assign sts.in_valid = i_in_valid;
    // Output register is free when empty or being drained this cycle
    assign sts.out_free = !r_out_valid || !i_out_stall;

    mcpi_ctrl #(
        .DIV_ITER (DIV_ITER)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mcpi_dp #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .NUM_CHANNELS   (NUM_CHANNELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg             (r_cfg),
        .i_channel         (i_channel),
        .i_current_raw     (i_current_raw),
        .i_velocity_counts (i_velocity_counts),
        .i_desired_current (i_desired_current),
        .o_channel         (dp_channel),
        .o_duty            (dp_duty),
        .o_reverse         (dp_reverse),
        .o_meas            (dp_meas)
    );

    // Output register: hold a stalled result, drop valid once it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out_channel <= dp_channel;
            r_duty        <= dp_duty;
            r_reverse     <= dp_reverse;
            r_meas        <= dp_meas;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_channel      = r_out_channel;
    assign o_duty_magnitude   = r_duty;
    assign o_reverse          = r_reverse;
    assign o_measured_current = r_meas;

endmodule
